### hdl/dmac_pkg.sv
// shared types, widths and codes for the dma channel register and fetch block
// no dependencies; used by the interfaces, dmac_core and the top level
package dmac_pkg;

   localparam int CHANNELS_DEFAULT = 4;

   localparam int PORT_W   = 8;
   localparam int DATA_W   = 8;
   localparam int CHAN_W   = 2;
   localparam int ADDR_W   = 24;
   localparam int BASE_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int PAGE_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic CMD_PORT_WRITE = 1'b0;
   localparam logic CMD_BYTE_REQ   = 1'b1;

   localparam logic [PORT_W-1:0] PORT_ADDRESS  = 8'h02;
   localparam logic [PORT_W-1:0] PORT_LIMIT    = 8'h03;
   localparam logic [PORT_W-1:0] PORT_MASK     = 8'h0A;
   localparam logic [PORT_W-1:0] PORT_MODE     = 8'h0B;
   localparam logic [PORT_W-1:0] PORT_CLEAR_FF = 8'h0C;
   localparam logic [PORT_W-1:0] PORT_PAGE     = 8'h83;

   localparam int MASK_BIT = 2;
   localparam int AUTO_BIT = 4;
   localparam int DIR_BIT  = 5;

   localparam logic [STATUS_W-1:0] STATUS_FETCH       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MASKED      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_WRITE_TAKEN = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_FULL = 17'h10000;

   typedef struct packed {
      logic              command;
      logic [PORT_W-1:0] port;
      logic [DATA_W-1:0] write_data;
      logic [CHAN_W-1:0] channel;
   } req_type;

   typedef struct packed {
      logic                fetch;
      logic [ADDR_W-1:0]   fetch_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

### hdl/dmac_channel_ifs.sv
// valid/ready channel interfaces for requests and results
// depends on dmac_pkg
interface dmac_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [dmac_pkg::PORT_W-1:0]       port;
   logic [dmac_pkg::DATA_W-1:0]       write_data;
   logic [dmac_pkg::CHAN_W-1:0]       channel;

   modport source (output valid, command, port, write_data, channel, input ready);
   modport sink   (input valid, command, port, write_data, channel, output ready);
endinterface

interface dmac_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              fetch;
   logic [dmac_pkg::ADDR_W-1:0]       fetch_address;
   logic [dmac_pkg::STATUS_W-1:0]     status;

   modport source (output valid, fetch, fetch_address, status, input ready);
   modport sink   (input valid, fetch, fetch_address, status, output ready);
endinterface

### hdl/dmac_core.sv
// per-channel register file, port write decode and fetch address logic
// depends on dmac_pkg
module dmac_core #(
   parameter int CHANNELS = dmac_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  dmac_pkg::req_type req,
   output dmac_pkg::rsp_type rsp
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] CH_ONE = CH_W'(1);

   logic [dmac_pkg::BASE_W-1:0]  base_ff [CHANNELS];
   logic [dmac_pkg::BASE_W-1:0]  base_in [CHANNELS];
   logic [dmac_pkg::COUNT_W-1:0] limit_ff [CHANNELS];
   logic [dmac_pkg::COUNT_W-1:0] limit_in [CHANNELS];
   logic [dmac_pkg::COUNT_W-1:0] prog_ff [CHANNELS];
   logic [dmac_pkg::COUNT_W-1:0] prog_in [CHANNELS];
   logic [dmac_pkg::PAGE_W-1:0]  page_ff [CHANNELS];
   logic [dmac_pkg::PAGE_W-1:0]  page_in [CHANNELS];
   logic [CHANNELS-1:0]          mask_ff, mask_in;
   logic [CHANNELS-1:0]          dir_ff, dir_in;
   logic [CHANNELS-1:0]          auto_ff, auto_in;
   logic                         hbn_ff, hbn_in;

   logic                         sel_ok;
   logic [CH_W-1:0]              sel_idx;
   logic                         ch_ok;
   logic [CH_W-1:0]              ch_idx;
   logic [dmac_pkg::COUNT_W-1:0] cur_prog;
   logic [dmac_pkg::COUNT_W-1:0] cur_lim;
   logic                         rewind;
   logic [dmac_pkg::COUNT_W-1:0] eff_prog;
   logic [dmac_pkg::ADDR_W-1:0]  base_full;
   logic [dmac_pkg::COUNT_W-1:0] lim_high;

   assign sel_ok    = 32'(req.write_data[1:0]) < CHANNELS;
   assign sel_idx   = CH_W'(req.write_data[1:0]);
   assign ch_ok     = 32'(req.channel) < CHANNELS;
   assign ch_idx    = CH_W'(req.channel);
   assign cur_prog  = prog_ff[ch_idx];
   assign cur_lim   = limit_ff[ch_idx];
   assign rewind    = auto_ff[ch_idx] && (cur_prog > cur_lim);
   assign eff_prog  = rewind ? '0 : cur_prog;
   assign base_full = {page_ff[ch_idx], base_ff[ch_idx]};
   assign lim_high  = {1'b0, req.write_data, limit_ff[CH_ONE][7:0]};

   always_comb begin
      base_in  = base_ff;
      limit_in = limit_ff;
      prog_in  = prog_ff;
      page_in  = page_ff;
      mask_in  = mask_ff;
      dir_in   = dir_ff;
      auto_in  = auto_ff;
      hbn_in   = hbn_ff;
      rsp      = '0;
      if (req.command == dmac_pkg::CMD_PORT_WRITE) begin
         rsp.status = dmac_pkg::STATUS_WRITE_TAKEN;
         if (fire) begin
            unique case (req.port)
               dmac_pkg::PORT_ADDRESS: begin
                  base_in[CH_ONE] = hbn_ff ? {req.write_data, base_ff[CH_ONE][7:0]}
                                           : {base_ff[CH_ONE][15:8], req.write_data};
                  hbn_in = !hbn_ff;
               end
               dmac_pkg::PORT_LIMIT: begin
                  if (hbn_ff) begin
                     limit_in[CH_ONE] = (lim_high == '0) ? dmac_pkg::COUNT_FULL : lim_high;
                     prog_in[CH_ONE]  = '0;
                  end else begin
                     limit_in[CH_ONE] = {1'b0, limit_ff[CH_ONE][15:8], req.write_data};
                  end
                  hbn_in = !hbn_ff;
               end
               dmac_pkg::PORT_MASK: begin
                  if (sel_ok) begin
                     mask_in[sel_idx] = req.write_data[dmac_pkg::MASK_BIT];
                  end
               end
               dmac_pkg::PORT_MODE: begin
                  if (sel_ok) begin
                     dir_in[sel_idx]  = req.write_data[dmac_pkg::DIR_BIT];
                     auto_in[sel_idx] = req.write_data[dmac_pkg::AUTO_BIT];
                  end
               end
               dmac_pkg::PORT_CLEAR_FF: begin
                  hbn_in = 1'b0;
               end
               dmac_pkg::PORT_PAGE: begin
                  page_in[CH_ONE] = req.write_data;
               end
               default: begin
               end
            endcase
         end
      end else if (!ch_ok || mask_ff[ch_idx]) begin
         rsp.status = dmac_pkg::STATUS_MASKED;
      end else if (eff_prog > cur_lim) begin
         rsp.status = dmac_pkg::STATUS_EXHAUSTED;
      end else begin
         rsp.status        = dmac_pkg::STATUS_FETCH;
         rsp.fetch         = 1'b1;
         rsp.fetch_address = dir_ff[ch_idx] ? base_full - 24'(eff_prog)
                                            : base_full + 24'(eff_prog);
         if (fire) begin
            prog_in[ch_idx] = eff_prog + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            base_ff[i]  <= '0;
            limit_ff[i] <= '0;
            prog_ff[i]  <= '0;
            page_ff[i]  <= '0;
         end
         mask_ff <= '0;
         dir_ff  <= '0;
         auto_ff <= '0;
         hbn_ff  <= 1'b0;
      end else begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         prog_ff  <= prog_in;
         page_ff  <= page_in;
         mask_ff  <= mask_in;
         dir_ff   <= dir_in;
         auto_ff  <= auto_in;
         hbn_ff   <= hbn_in;
      end
   end

   // high limit byte restarts channel 1 and never leaves a zero limit
   assert property (@(posedge clock) disable iff (reset)
      fire && req.command == dmac_pkg::CMD_PORT_WRITE && req.port == dmac_pkg::PORT_LIMIT
      && hbn_ff |=> prog_ff[CH_ONE] == '0 && limit_ff[CH_ONE] != '0)
      else $error("limit high byte did not restart channel 1");

   // byte pointer toggles on every address or limit byte
   assert property (@(posedge clock) disable iff (reset)
      fire && req.command == dmac_pkg::CMD_PORT_WRITE
      && (req.port == dmac_pkg::PORT_ADDRESS || req.port == dmac_pkg::PORT_LIMIT)
      |=> hbn_ff != $past(hbn_ff))
      else $error("byte pointer did not toggle");

   // a masked or exhausted request leaves the channel count alone
   assert property (@(posedge clock) disable iff (reset)
      fire && req.command == dmac_pkg::CMD_BYTE_REQ && ch_ok && !rewind
      && rsp.status != dmac_pkg::STATUS_FETCH |=> prog_ff[$past(ch_idx)] == $past(cur_prog))
      else $error("count moved without a fetch");

   // a fetched byte always advances the count
   assert property (@(posedge clock) disable iff (reset)
      fire && rsp.fetch |=> prog_ff[$past(ch_idx)] == $past(eff_prog) + 17'd1)
      else $error("count did not advance after fetch");

endmodule

### hdl/dma_channel_register_and_fetch_top.sv
// top level: request input register, dmac_core and result output register
// depends on dmac_pkg, dmac_req_if, dmac_rsp_if and dmac_core
//
// usage:
//   req_if carries one transfer per item: a port write (command 0, port and
//   write_data) or a dma byte request (command 1, channel). rsp_if returns
//   exactly one result per request, in order: fetch, fetch_address and status
//   (0 fetch issued, 1 masked, 2 exhausted, 3 port write taken).
//   a transfer is taken at a rising edge with valid and ready both high.
//   registers: one for the request and one for the result; all decode,
//   count compare and the 24-bit address add/subtract sit between them.
//   throughput: one transfer per cycle, sustained while rsp_if.ready stays
//   high, set by the single pass through dmac_core with channel state
//   updated in the same cycle.
//   stall: while the result register is full and rsp_if.ready is low the
//   request register holds; req_if.ready drops only once both are full.
//   reset: synchronous, active high; clears both valid flags, every channel's
//   address, limit, count, page, mask and mode, and the byte pointer.
module dma_channel_register_and_fetch_top #(
   parameter int CHANNELS = dmac_pkg::CHANNELS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   dmac_req_if.sink   req_if,
   dmac_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   dmac_pkg::req_type in_data_ff, in_data_in;
   logic              out_valid_ff, out_valid_in;
   dmac_pkg::rsp_type out_data_ff, out_data_in;
   dmac_pkg::rsp_type core_rsp;
   logic              advance;
   logic              take;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign in_data_in   = take ? dmac_pkg::req_type'({req_if.command, req_if.port,
                                                    req_if.write_data, req_if.channel})
                              : in_data_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
   assign out_data_in  = advance ? core_rsp : out_data_ff;

   dmac_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.fetch         = out_data_ff.fetch;
   assign rsp_if.fetch_address = out_data_ff.fetch_address;
   assign rsp_if.status        = out_data_ff.status;

   // fetch flag and status agree, and no address leaks without a fetch
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.fetch == (out_data_ff.status == dmac_pkg::STATUS_FETCH))
      && (out_data_ff.fetch || out_data_ff.fetch_address == '0))
      else $error("fetch flag and status disagree");

   // a port write always answers write taken
   assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.command == dmac_pkg::CMD_PORT_WRITE
      |=> out_data_ff.status == dmac_pkg::STATUS_WRITE_TAKEN)
      else $error("port write answered with wrong status");

   // every advance lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request lost");

endmodule
